// ----- hdl/tpi_pkg.sv -----
package tpi_pkg;

    localparam int TRACK_DEPTH = 4096;
    localparam int AW = $clog2(TRACK_DEPTH);
    localparam int CW = $clog2(TRACK_DEPTH + 1);

    localparam int TW = 48;
    localparam int VW = 32;
    localparam int NW = TW + 1;
    localparam int BW = 34;
    localparam int RW = NW + 1;
    localparam int MW = TW + 2 * VW;

    localparam logic signed [VW-1:0] LAT_LIMIT = 32'sd900000000;
    localparam logic signed [VW-1:0] LON_LIMIT = 32'sd1800000000;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FEW       = 3'd1;
    localparam logic [2:0] ST_NOT_MONO  = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_BAD_COORD = 3'd4;

    typedef struct packed {
        logic          start;
        logic [NW-1:0] a;
        logic [BW-1:0] b;
        logic [NW-1:0] d;
    } t_md_req;

    typedef struct packed {
        logic          done;
        logic [BW-1:0] q;
    } t_md_rsp;

endpackage

// ----- hdl/tpi_store.sv -----
module tpi_store
    import tpi_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [MW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [MW-1:0] o_rdata
);

    logic [MW-1:0] r_mem [TRACK_DEPTH];
    logic [MW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tpi_muldiv.sv -----
module tpi_muldiv
    import tpi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    logic                  r_busy;
    logic [5:0]            r_cnt;
    logic [RW-1:0]         r_rem;
    logic [BW-1:0]         r_quo;
    logic [BW-1:0]         r_b;
    logic [NW-1:0]         r_a;
    logic [NW-1:0]         r_d;
    logic                  r_done;
    logic [RW-1:0]         n_rem;
    logic [BW-1:0]         n_quo;
    logic [RW-1:0]         s1;
    logic [RW-1:0]         s2;
    logic [BW-1:0]         q1;

    always_comb begin
        s1 = {r_rem[RW-2:0], 1'b0};
        q1 = {r_quo[BW-2:0], 1'b0};
        if (s1 >= {1'b0, r_d}) begin
            s1 = s1 - {1'b0, r_d};
            q1 = q1 + 1'b1;
        end
        s2 = s1;
        n_quo = q1;
        if (r_b[BW-1]) begin
            s2 = s1 + {1'b0, r_a};
            if (s2 >= {1'b0, r_d}) begin
                s2 = s2 - {1'b0, r_d};
                n_quo = q1 + 1'b1;
            end
        end
        n_rem = s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(BW - 1);
                r_rem  <= '0;
                r_quo  <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_d    <= i_req.d;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_b   <= {r_b[BW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_quo;

endmodule

// ----- hdl/track_position_interpolator.sv -----
// Channel | Direction | tdata (low bit up)              | tuser
// s_axis  | in        | time_ms 48, lat_in 32, lon_in 32 | mode 2
// m_axis  | out       | lat_out 31, lon_out 32, pad 1    | status 3
//
// Clear and append are handled as the transfer is accepted; the previous time sits in a register.
// A query runs a binary search of at most 13 steps, each a read and a compare,
// then closes the search, does the exact-match check and the bracketing reads,
// and runs two multiply-divide passes, latitude first, then longitude.
// Reset is synchronous, active low; the sample memory needs no clearing pass.
// A finished result holds in the output register until transferred.
module track_position_interpolator
    import tpi_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [111:0]   i_s_axis_tdata,   // time_ms, lat_in, lon_in
    input  logic [1:0]     i_s_axis_tuser,   // mode
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [63:0]    o_m_axis_tdata,   // lat_out, lon_out
    output logic [2:0]     o_m_axis_tuser    // status
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_SRD  = 11'b00000000010,
        S_SCMP = 11'b00000000100,
        S_XCHK = 11'b00000001000,
        S_LD0  = 11'b00000010000,
        S_LD1  = 11'b00000100000,
        S_CALC = 11'b00001000000,
        S_LAT  = 11'b00010000000,
        S_LON  = 11'b00100000000,
        S_OUT  = 11'b01000000000,
        S_WAIT = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic r_nd, r_ni, r_asc;
    logic signed [TW-1:0] r_first, r_last, r_q;
    logic [CW-1:0] r_lo, r_hi, r_mid;
    logic [AW-1:0] r_i1;
    logic signed [TW-1:0] r_t0;
    logic signed [VW-1:0] r_la0, r_lo0, r_la1, r_lo1;
    logic [2:0] r_stat;
    logic signed [VW-1:0] r_rla, r_rlo;
    logic r_ov;
    logic [2:0] r_ostat;
    logic [62:0] r_odata;
    logic r_nd_den;
    logic [NW-1:0] r_mnum, r_mden;

    logic [AW-1:0] raddr;
    logic [MW-1:0] rdata;
    logic we;
    t_md_req md_req;
    t_md_rsp md_rsp;

    logic acc;
    logic [1:0] mode;
    logic signed [TW-1:0] in_t;
    logic signed [TW-1:0] rd_t;
    logic signed [VW-1:0] rd_la, rd_lo;
    logic [CW-1:0] mid;
    logic is_before;
    logic signed [NW-1:0] num, den;
    logic signed [VW:0] dv_la, dv_lo;
    logic [NW-1:0] mag_num, mag_den;
    logic neg_la, neg_lo;
    logic signed [BW-1:0] res;
    logic [AW-1:0] idx;

    function automatic logic c_ok(logic signed [VW-1:0] la, logic signed [VW-1:0] lo);
        return la >= -LAT_LIMIT && la <= LAT_LIMIT && lo >= -LON_LIMIT && lo <= LON_LIMIT;
    endfunction

    function automatic logic [BW-1:0] mag_v(logic signed [VW:0] v);
        logic signed [BW-1:0] x;
        x = BW'(v);
        return x < 0 ? BW'(-x) : BW'(x);
    endfunction

    assign mode  = i_s_axis_tuser;
    assign in_t  = i_s_axis_tdata[TW-1:0];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign rd_t  = rdata[TW-1:0];
    assign rd_la = rdata[TW+VW-1:TW];
    assign rd_lo = rdata[MW-1:TW+VW];
    assign mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign is_before = r_asc ? (rd_t < r_q) : (rd_t > r_q);
    assign idx   = r_lo[AW-1:0];
    assign we    = acc && mode == MODE_APPEND && r_count < CW'(TRACK_DEPTH);

    assign num = NW'(r_q) - NW'(r_t0);
    assign den = NW'(rd_t) - NW'(r_t0);
    assign mag_num = num < 0 ? NW'(-num) : NW'(num);
    assign mag_den = den < 0 ? NW'(-den) : NW'(den);
    assign dv_la = (VW+1)'(r_la1) - (VW+1)'(r_la0);
    assign dv_lo = (VW+1)'(r_lo1) - (VW+1)'(r_lo0);
    assign neg_la = ((num < 0) != r_nd_den) != (dv_la < 0);
    assign neg_lo = ((num < 0) != r_nd_den) != (dv_lo < 0);

    always_comb begin
        unique case (r_state)
            S_SRD:   raddr = mid[AW-1:0];
            S_XCHK:  raddr = (idx == '0) ? '0 : idx - 1'b1;
            S_LD0:   raddr = r_i1;
            default: raddr = mid[AW-1:0];
        endcase
    end

    always_comb begin
        md_req.start = 1'b0;
        md_req.a = r_mnum;
        md_req.d = r_mden;
        md_req.b = mag_v(dv_la);
        if (r_state == S_CALC && c_ok(r_la0, r_lo0) && c_ok(r_la1, r_lo1) && r_mden != '0) begin
            md_req.start = 1'b1;
        end
        if (r_state == S_LAT && md_rsp.done) begin
            md_req.start = 1'b1;
            md_req.b = mag_v(dv_lo);
        end
        res = (r_state == S_LAT)
            ? (neg_la ? BW'(r_la0) - md_rsp.q : BW'(r_la0) + md_rsp.q)
            : (neg_lo ? BW'(r_lo0) - md_rsp.q : BW'(r_lo0) + md_rsp.q);
    end

    tpi_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_s_axis_tdata[MW-1:0]),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tpi_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_nd    <= 1'b1;
            r_ni    <= 1'b1;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_m_axis_tready && r_state != S_WAIT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        unique case (mode)
                            MODE_CLEAR: begin
                                r_count <= '0;
                                r_nd <= 1'b1;
                                r_ni <= 1'b1;
                            end
                            MODE_APPEND: begin
                                if (we) begin
                                    if (r_count != '0) begin
                                        if (in_t < r_last) r_nd <= 1'b0;
                                        if (in_t > r_last) r_ni <= 1'b0;
                                    end else begin
                                        r_first <= in_t;
                                    end
                                    r_last  <= in_t;
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            MODE_QUERY: begin
                                r_q   <= in_t;
                                r_asc <= r_last >= r_first;
                                r_rla <= '0;
                                r_rlo <= '0;
                                r_lo  <= '0;
                                r_hi  <= r_count;
                                r_state <= S_OUT;
                                if (r_count < CW'(2)) begin
                                    r_stat <= ST_FEW;
                                end else if (r_last >= r_first ? !r_nd : !r_ni) begin
                                    r_stat <= ST_NOT_MONO;
                                end else if (r_last >= r_first
                                        ? (in_t < r_first || in_t > r_last)
                                        : (in_t > r_first || in_t < r_last)) begin
                                    r_stat <= ST_OUTSIDE;
                                end else begin
                                    r_stat <= ST_OK;
                                    r_state <= S_SRD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SRD: begin
                    if (r_lo < r_hi) begin
                        r_mid <= mid;
                        r_state <= S_SCMP;
                    end else if (r_lo >= r_count) begin
                        r_stat <= ST_OUTSIDE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_XCHK;
                    end
                end
                S_SCMP: begin
                    if (is_before) r_lo <= r_mid + 1'b1;
                    else           r_hi <= r_mid;
                    r_state <= S_SRD;
                end
                S_XCHK: begin
                    if (rd_t == r_q) begin
                        if (c_ok(rd_la, rd_lo)) begin
                            r_rla <= rd_la;
                            r_rlo <= rd_lo;
                        end else begin
                            r_stat <= ST_BAD_COORD;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_i1 <= (idx == '0) ? AW'(1) : idx;
                        r_state <= S_LD0;
                    end
                end
                S_LD0: begin
                    r_t0  <= rd_t;
                    r_la0 <= rd_la;
                    r_lo0 <= rd_lo;
                    r_state <= S_LD1;
                end
                S_LD1: begin
                    r_la1 <= rd_la;
                    r_lo1 <= rd_lo;
                    r_mnum <= mag_num;
                    r_mden <= mag_den;
                    r_nd_den <= den < 0;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (!c_ok(r_la0, r_lo0) || !c_ok(r_la1, r_lo1)) begin
                        r_stat <= ST_BAD_COORD;
                        r_state <= S_OUT;
                    end else if (r_mden == '0) begin
                        r_rla <= r_la0;
                        r_rlo <= r_lo0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_LAT;
                    end
                end
                S_LAT: begin
                    if (md_rsp.done) begin
                        r_rla <= VW'(res);
                        r_state <= S_LON;
                    end
                end
                S_LON: begin
                    if (md_rsp.done) begin
                        r_rlo <= VW'(res);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!r_ov || i_m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_ostat <= r_stat;
                        r_odata <= {r_rlo, r_rla[VW-2:0]};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tdata  = {1'b0, r_odata};

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TRACK_DEPTH))
        else $error("sample count beyond depth");
    a_md_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == S_LAT || r_state == S_LON))
        else $error("divide result outside interpolation");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> o_m_axis_tdata == '0)
        else $error("failed query carries a position");
`endif

endmodule
